>>> rtl/b64url_pkg.sv
// ----------------------------------------------------------------------------
// b64url_pkg
// Shared types and character codes for the base64url decoder.
// ----------------------------------------------------------------------------
package b64url_pkg;

    localparam int CHAR_W = 8;
    localparam int SYM_W  = 6;
    localparam int BUF_W  = 8;
    localparam int CNT_W  = 3;

    localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D; // '='
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D; // '-'
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B; // '+'
    localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F; // '_'
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F; // '/'
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;

    localparam logic [SYM_W-1:0] SYM_LOWER_BASE = 6'd26;
    localparam logic [SYM_W-1:0] SYM_DIGIT_BASE = 6'd52;
    localparam logic [SYM_W-1:0] SYM_62         = 6'd62;
    localparam logic [SYM_W-1:0] SYM_63         = 6'd63;

    // Classification of one character
    typedef struct packed {
        logic             skip;
        logic             invalid;
        logic [SYM_W-1:0] value;
    } sym_info_t;

endpackage

>>> rtl/b64url_sym_decode.sv
// ----------------------------------------------------------------------------
// b64url_sym_decode
// Maps one character to its six-bit symbol, or flags it as skipped/invalid.
// ----------------------------------------------------------------------------
module b64url_sym_decode (
    input  logic [b64url_pkg::CHAR_W-1:0] char_in,
    output b64url_pkg::sym_info_t         sym_out
);
    import b64url_pkg::*;

    logic [CHAR_W-1:0] off_upper;
    logic [CHAR_W-1:0] off_lower;
    logic [CHAR_W-1:0] off_digit;

    assign off_upper = char_in - CH_UPPER_A;
    assign off_lower = char_in - CH_LOWER_A;
    assign off_digit = char_in - CH_DIGIT_0;

    always_comb begin
        sym_out = '0;
        if (char_in == CH_PAD || char_in == CH_LF || char_in == CH_CR
                || char_in == CH_SPACE) begin
            sym_out.skip = 1'b1;
        end else if (char_in >= CH_UPPER_A && char_in <= CH_UPPER_Z) begin
            sym_out.value = off_upper[SYM_W-1:0];
        end else if (char_in >= CH_LOWER_A && char_in <= CH_LOWER_Z) begin
            sym_out.value = off_lower[SYM_W-1:0] + SYM_LOWER_BASE;
        end else if (char_in >= CH_DIGIT_0 && char_in <= CH_DIGIT_9) begin
            sym_out.value = off_digit[SYM_W-1:0] + SYM_DIGIT_BASE;
        end else if (char_in == CH_MINUS || char_in == CH_PLUS) begin
            sym_out.value = SYM_62;
        end else if (char_in == CH_USCORE || char_in == CH_SLASH) begin
            sym_out.value = SYM_63;
        end else begin
            sym_out.invalid = 1'b1;
        end
    end

endmodule

>>> rtl/base64url_decoder_top.sv
// ----------------------------------------------------------------------------
// base64url_decoder_top
// Streaming base64 decoder, URL-safe and standard alphabets, one character
// per request in, one result per request out.
// ----------------------------------------------------------------------------
// Channel | Dir | Signals                        | Contents
// s_      | in  | tvalid tready tdata tlast      | tdata = char_in, tlast = last_char
// m_      | out | tvalid tready tdata tuser tlast| tdata = data_byte,
//         |     |                                | tuser = {decode_error, byte_valid},
//         |     |                                | tlast = string_end
//
// One character is accepted per cycle while s_tready is high; its result is
// captured in the output register. The decoder state updates at acceptance.
// s_tready is high while the output register is empty or being drained, so a
// stall on m_ holds the result and blocks input only while it waits.
// aresetn (synchronous, active low) clears buffer, count, error and m_tvalid.
// ----------------------------------------------------------------------------
module base64url_decoder_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // last_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] decode_error
    output logic       m_tlast    // string_end
);
    import b64url_pkg::*;

    sym_info_t sym;

    logic [BUF_W-1:0] buf_reg,   buf_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             err_reg,   err_next;

    logic             m_valid_reg;
    logic [7:0]       m_data_reg,  m_data_next;
    logic [1:0]       m_user_reg,  m_user_next;
    logic             m_last_reg;

    logic                   accept;
    logic [BUF_W+SYM_W-1:0] acc;
    logic [CNT_W:0]         cnt_sum;
    logic [CNT_W:0]         cnt_left;
    logic [BUF_W+SYM_W-1:0] acc_shr;
    logic                   byte_valid;

    b64url_sym_decode u_sym (
        .char_in (s_tdata),
        .sym_out (sym)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign acc      = {buf_reg, sym.value};
    assign cnt_sum  = {1'b0, cnt_reg} + (CNT_W+1)'(SYM_W);
    assign cnt_left = cnt_sum - (CNT_W+1)'(8);
    assign acc_shr  = acc >> cnt_left;

    always_comb begin
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        byte_valid  = 1'b0;
        m_data_next = '0;
        if (!err_reg) begin
            if (sym.invalid) begin
                err_next = 1'b1;
            end else if (!sym.skip) begin
                buf_next = acc[BUF_W-1:0];
                if (cnt_sum >= (CNT_W+1)'(8)) begin
                    byte_valid  = 1'b1;
                    m_data_next = acc_shr[7:0];
                    cnt_next    = cnt_left[CNT_W-1:0];
                end else begin
                    cnt_next    = cnt_sum[CNT_W-1:0];
                end
            end
        end
        m_user_next = {err_next, byte_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg     <= '0;
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                // drop leftover bits and the error at the end of a string
                if (s_tlast) begin
                    buf_reg <= '0;
                    cnt_reg <= '0;
                    err_reg <= 1'b0;
                end else begin
                    buf_reg <= buf_next;
                    cnt_reg <= cnt_next;
                    err_reg <= err_next;
                end
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
            m_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> verif/base64url_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_decoder_checker
// Watches both channels of the decoder and keeps its own copy of the bit
// buffer, count and error flag. Every accepted character is decoded here and
// the expected result queued. Each result on m_ is checked field by field
// against the oldest queued entry.
// ----------------------------------------------------------------------------
module base64url_decoder_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    input  logic       m_tlast,
    output int         fail_count,
    output int         outstanding
);
    import b64url_pkg::*;

    typedef enum logic [1:0] {CLS_SYMBOL, CLS_SKIP, CLS_BAD} char_class_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       decode_error;
        logic       string_end;
    } decoded_t;

    decoded_t   decoded_q[$];
    logic [7:0] bits_held;
    logic [2:0] bits_pending;
    logic       error_latched;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic char_class_t classify(input logic [7:0] ch, output logic [5:0] sym);
        logic [7:0] offs;
        sym = '0;
        if (ch == CH_PAD || ch == CH_LF || ch == CH_CR || ch == CH_SPACE) begin
            return CLS_SKIP;
        end
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            offs = ch - CH_UPPER_A;
            sym  = offs[5:0];
            return CLS_SYMBOL;
        end
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            offs = ch - CH_LOWER_A;
            sym  = SYM_LOWER_BASE + offs[5:0];
            return CLS_SYMBOL;
        end
        if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            offs = ch - CH_DIGIT_0;
            sym  = SYM_DIGIT_BASE + offs[5:0];
            return CLS_SYMBOL;
        end
        if (ch == CH_MINUS || ch == CH_PLUS) begin
            sym = SYM_62;
            return CLS_SYMBOL;
        end
        if (ch == CH_USCORE || ch == CH_SLASH) begin
            sym = SYM_63;
            return CLS_SYMBOL;
        end
        return CLS_BAD;
    endfunction

    // Advance the decoder state by one character and return its result
    function automatic decoded_t decode_char(input logic [7:0] ch, input logic is_last);
        char_class_t cls;
        logic [5:0]  sym;
        logic [13:0] acc;
        logic [13:0] shifted;
        logic [3:0]  cnt;
        decoded_t    res;
        res = '0;
        res.string_end = is_last;
        if (!error_latched) begin
            cls = classify(ch, sym);
            if (cls == CLS_BAD) begin
                error_latched = 1'b1;
            end else if (cls == CLS_SYMBOL) begin
                acc = {bits_held, sym};
                cnt = bits_pending + 4'd6;
                if (cnt >= 4'd8) begin
                    cnt            = cnt - 4'd8;
                    shifted        = acc >> cnt;
                    res.data_byte  = shifted[7:0];
                    res.byte_valid = 1'b1;
                end
                bits_held    = acc[7:0];
                bits_pending = cnt[2:0];
            end
        end
        res.decode_error = error_latched;
        // drop leftover partial bits at the end of the string
        if (is_last) begin
            bits_held     = '0;
            bits_pending  = '0;
            error_latched = 1'b0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        decoded_t want;
        if (!aresetn) begin
            decoded_q.delete();
            bits_held     = '0;
            bits_pending  = '0;
            error_latched = 1'b0;
            outstanding  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decoded_q.insert(decoded_q.size(), decode_char(s_tdata, s_tlast));
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: tdata %0h tuser %0b tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count = fail_count + 1;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tuser[0] !== want.byte_valid) begin
                        $error("byte_valid: expected %0b, actual %0b",
                               want.byte_valid, m_tuser[0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_tdata !== want.data_byte) begin
                        $error("data_byte: expected %0h, actual %0h",
                               want.data_byte, m_tdata);
                        fail_count = fail_count + 1;
                    end
                    if (m_tuser[1] !== want.decode_error) begin
                        $error("decode_error: expected %0b, actual %0b",
                               want.decode_error, m_tuser[1]);
                        fail_count = fail_count + 1;
                    end
                    if (m_tlast !== want.string_end) begin
                        $error("string_end: expected %0b, actual %0b",
                               want.string_end, m_tlast);
                        fail_count = fail_count + 1;
                    end
                end
            end
            outstanding <= decoded_q.size();
        end
    end

endmodule

>>> verif/base64url_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_decoder_top_tb
// Feeds the decoder directed strings (both alphabets, skipped characters,
// invalid codes, last marker on every kind of character) and then random
// strings, mostly well formed, with random gaps on both channels.
// ----------------------------------------------------------------------------
module base64url_decoder_top_tb;
    import b64url_pkg::*;

    localparam int CHAR_TARGET = 1450;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;
    int         fail_count;
    int         outstanding;
    int         chars_sent = 0;
    int         tx_calm = 0;
    int         rx_calm = 0;

    always #10 aclk = ~aclk;

    base64url_decoder_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    base64url_decoder_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Gap before the next request; now and then a run of back-to-back ones
    function automatic int pick_gap(inout int calm);
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 40) == 0) begin
            calm = $urandom_range(20, 60);
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [7:0] symbol_char(input int v, input bit std_alpha);
        if (v < 26) begin
            return CH_UPPER_A + 8'(v);
        end
        if (v < 52) begin
            return CH_LOWER_A + 8'(v - 26);
        end
        if (v < 62) begin
            return CH_DIGIT_0 + 8'(v - 52);
        end
        if (v == 62) begin
            return std_alpha ? CH_PLUS : CH_MINUS;
        end
        return std_alpha ? CH_SLASH : CH_USCORE;
    endfunction

    function automatic logic [7:0] skip_char();
        case ($urandom_range(0, 3))
            0: return CH_PAD;
            1: return CH_LF;
            2: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic is_last);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], i == txt.len() - 1);
        end
    endtask

    // Hold the input until every queued result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, and two long hold-offs to back up the input
    initial begin : receiver
        int stall;
        int taken;
        taken = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pick_gap(rx_calm);
            if (taken == 100 || taken == 900) begin
                stall = 150;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    initial begin : stimulus
        int         len;
        int         kind;
        int         broken_at;
        logic [7:0] ch;
        bit         std_alpha;
        bit         paused;
        paused = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text("TWFu");
        send_text("-_+/");
        send_text("Az09");
        send_text("QQ=\r\n ");
        send_text("Z");
        send_char(8'h7A, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_UPPER_A, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(8'h80, 1'b1);
        drain();

        while (chars_sent < CHAR_TARGET) begin
            if (!paused && chars_sent >= CHAR_TARGET / 2) begin
                paused = 1'b1;
                drain();
            end
            len       = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                    : $urandom_range(1, 24);
            kind      = $urandom_range(0, 9);
            std_alpha = 1'($urandom_range(0, 1));
            broken_at = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++) begin
                if (kind == 0) begin
                    ch = 8'($urandom_range(0, 255));
                end else if (kind == 1 && i == broken_at) begin
                    ch = 8'($urandom_range(0, 255));
                end else if ($urandom_range(0, 7) == 0) begin
                    ch = skip_char();
                end else begin
                    ch = symbol_char($urandom_range(0, 63), std_alpha);
                end
                send_char(ch, i == len - 1);
            end
        end
        drain();
        repeat (10) @(posedge aclk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
